// ===== rtl/bas_pkg.sv =====
package bas_pkg;

   localparam int MAX_CANDIDATES = 16;
   localparam int CNT_W          = $clog2(MAX_CANDIDATES + 2);
   localparam int POS_W          = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int TIE_W          = $clog2(MAX_CANDIDATES + 1);

   localparam int INDEX_W = 4;
   localparam int TIED_W  = 5;
   localparam int SCORE_W = 32;
   localparam int ED_W    = 16;
   localparam int MAPQ_W  = 8;
   localparam int MSUM_W  = MAPQ_W + 1;
   localparam int ADDR_W  = 4;
   localparam int DATA_W  = 32;

   localparam logic signed [SCORE_W-1:0] SCORE_MIN  = 32'sh8000_0000;
   localparam logic signed [SCORE_W-1:0] SCORE_HALF = 32'shC000_0000;

   typedef enum logic [1:0] {
      REG_PAIRED_MODE  = 2'd0,
      REG_MERGE_BY_MAX = 2'd1,
      REG_CONSERVATIVE = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic paired_mode;
      logic merge_by_max;
      logic report_minima;
   } cfg_type;

   typedef struct packed {
      logic              proper_pair;
      logic              first_unmapped;
      logic              first_tag_present;
      logic [ED_W-1:0]   first_edit_distance;
      logic [MAPQ_W-1:0] first_mapq;
      logic              second_unmapped;
      logic              second_tag_present;
      logic [ED_W-1:0]   second_edit_distance;
      logic [MAPQ_W-1:0] second_mapq;
      logic              last_candidate;
   } req_type;

   typedef struct packed {
      logic                       pair;
      logic signed [SCORE_W-1:0]  score;
      logic [MSUM_W-1:0]          mapq;
      logic [MAPQ_W-1:0]          mapq_first;
      logic [MAPQ_W-1:0]          mapq_second;
   } key_type;

endpackage

// ===== rtl/bas_key.sv =====
module bas_key (
   input  bas_pkg::cfg_type cfg,
   input  bas_pkg::req_type item,
   output bas_pkg::key_type key
);
   import bas_pkg::*;

   logic                      valid_first;
   logic                      valid_second;
   logic signed [SCORE_W-1:0] neg_first;
   logic signed [SCORE_W-1:0] neg_second;
   logic signed [SCORE_W-1:0] max_first;
   logic signed [SCORE_W-1:0] max_second;
   logic signed [SCORE_W-1:0] sum_first;
   logic signed [SCORE_W-1:0] sum_second;

   assign valid_first  = !item.first_unmapped && item.first_tag_present;
   assign valid_second = !item.second_unmapped && item.second_tag_present;
   assign neg_first    = -$signed({{(SCORE_W-ED_W){1'b0}}, item.first_edit_distance});
   assign neg_second   = -$signed({{(SCORE_W-ED_W){1'b0}}, item.second_edit_distance});
   assign max_first    = valid_first  ? neg_first  : SCORE_MIN;
   assign max_second   = valid_second ? neg_second : SCORE_MIN;
   assign sum_first    = valid_first  ? neg_first  : SCORE_HALF;
   assign sum_second   = valid_second ? neg_second : SCORE_HALF;

   always_comb begin
      key.mapq_first = item.first_mapq;
      if (!cfg.paired_mode) begin
         key.pair        = 1'b1;
         key.score       = max_first;
         key.mapq        = MSUM_W'(item.first_mapq);
         key.mapq_second = '0;
      end else if (!cfg.merge_by_max) begin
         key.pair        = item.proper_pair;
         key.score       = sum_first + sum_second;
         key.mapq        = MSUM_W'(item.first_mapq) + MSUM_W'(item.second_mapq);
         key.mapq_second = item.second_mapq;
      end else begin
         key.pair        = item.proper_pair;
         key.score       = (max_second > max_first) ? max_second : max_first;
         key.mapq        = (item.first_mapq > item.second_mapq) ?
                           MSUM_W'(item.first_mapq) : MSUM_W'(item.second_mapq);
         key.mapq_second = item.second_mapq;
      end
   end

endmodule

// ===== rtl/best_alignment_selector.sv =====
// Picks the best of a read's candidate alignments. Each request is one candidate; the
// request with req_last_candidate set closes the run and yields one result (best index,
// tie count, winner's merged score and MAPQs or run minima, overflow flag). Requests are
// taken one per cycle while the input is not stalled: a request is registered, then its
// key is formed and compared against the running best, and the result is loaded into the
// output register as the closing request leaves the input register. A closing request
// held behind a result that has not yet been taken stalls the input until the output
// register frees. Ties go to the lowest index. Candidates beyond MAX_CANDIDATES in a run
// are ignored and flagged. Configure only while no run is open.
module best_alignment_selector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_proper_pair,
   input  logic                           req_first_unmapped,
   input  logic                           req_first_tag_present,
   input  logic [bas_pkg::ED_W-1:0]       req_first_edit_distance,
   input  logic [bas_pkg::MAPQ_W-1:0]     req_first_mapq,
   input  logic                           req_second_unmapped,
   input  logic                           req_second_tag_present,
   input  logic [bas_pkg::ED_W-1:0]       req_second_edit_distance,
   input  logic [bas_pkg::MAPQ_W-1:0]     req_second_mapq,
   input  logic                           req_last_candidate,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bas_pkg::INDEX_W-1:0]    rsp_best_index,
   output logic [bas_pkg::TIED_W-1:0]     rsp_tied_count,
   output logic signed [bas_pkg::SCORE_W-1:0] rsp_best_score,
   output logic [bas_pkg::MAPQ_W-1:0]     rsp_report_mapq_first,
   output logic [bas_pkg::MAPQ_W-1:0]     rsp_report_mapq_second,
   output logic                           rsp_count_overflow,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bas_pkg::ADDR_W-1:0]     csr_paddr,
   input  logic [bas_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [bas_pkg::DATA_W-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import bas_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff;
   req_type req_item;
   key_type key;
   logic    advance;

   logic [CNT_W-1:0]          cnt_ff, cnt_in, upd_cnt;
   logic                      bpair_ff, bpair_in, upd_bpair;
   logic signed [SCORE_W-1:0] bscore_ff, bscore_in, upd_bscore;
   logic [MSUM_W-1:0]         bmapq_ff, bmapq_in, upd_bmapq;
   logic [POS_W-1:0]          pos_ff, pos_in, upd_pos;
   logic [TIE_W-1:0]          tie_ff, tie_in, upd_tie;
   logic [MAPQ_W-1:0]         winq1_ff, winq1_in, upd_winq1;
   logic [MAPQ_W-1:0]         winq2_ff, winq2_in, upd_winq2;
   logic [MAPQ_W-1:0]         minq1_ff, minq1_in, upd_minq1;
   logic [MAPQ_W-1:0]         minq2_ff, minq2_in, upd_minq2;
   logic                      taken, better, equal;

   logic                      rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic [TIED_W-1:0]         rsp_tied_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;
   logic [MAPQ_W-1:0]         rsp_q1_ff, rsp_q2_ff;
   logic                      rsp_ovf_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      cfg_in     = cfg_ff;
      csr_prdata = '0;
      unique case (csr_index)
         REG_PAIRED_MODE: begin
            csr_prdata = DATA_W'(cfg_ff.paired_mode);
            if (csr_psel && csr_penable && csr_pwrite) cfg_in.paired_mode = csr_pwdata[0];
         end
         REG_MERGE_BY_MAX: begin
            csr_prdata = DATA_W'(cfg_ff.merge_by_max);
            if (csr_psel && csr_penable && csr_pwrite) cfg_in.merge_by_max = csr_pwdata[0];
         end
         REG_CONSERVATIVE: begin
            csr_prdata = DATA_W'(cfg_ff.report_minima);
            if (csr_psel && csr_penable && csr_pwrite)
               cfg_in.report_minima = csr_pwdata[0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // input register
   assign req_item = '{
      proper_pair:          req_proper_pair,
      first_unmapped:       req_first_unmapped,
      first_tag_present:    req_first_tag_present,
      first_edit_distance:  req_first_edit_distance,
      first_mapq:           req_first_mapq,
      second_unmapped:      req_second_unmapped,
      second_tag_present:   req_second_tag_present,
      second_edit_distance: req_second_edit_distance,
      second_mapq:          req_second_mapq,
      last_candidate:       req_last_candidate
   };

   assign advance     = s1_valid_ff && (!s1_ff.last_candidate || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || advance;
   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);

   bas_key u_key (
      .cfg  (cfg_ff),
      .item (s1_ff),
      .key  (key)
   );

   // running best
   assign taken  = cnt_ff < CNT_W'(MAX_CANDIDATES);
   assign better = (cnt_ff == '0) || (key.pair && !bpair_ff) ||
                   ((key.pair == bpair_ff) && (key.score > bscore_ff)) ||
                   ((key.pair == bpair_ff) && (key.score == bscore_ff) && (key.mapq > bmapq_ff));
   assign equal  = (key.pair == bpair_ff) && (key.score == bscore_ff) && (key.mapq == bmapq_ff);

   always_comb begin
      upd_cnt    = cnt_ff;
      upd_bpair  = bpair_ff;
      upd_bscore = bscore_ff;
      upd_bmapq  = bmapq_ff;
      upd_pos    = pos_ff;
      upd_tie    = tie_ff;
      upd_winq1  = winq1_ff;
      upd_winq2  = winq2_ff;
      upd_minq1  = minq1_ff;
      upd_minq2  = minq2_ff;
      if (taken) begin
         if (better) begin
            upd_bpair  = key.pair;
            upd_bscore = key.score;
            upd_bmapq  = key.mapq;
            upd_pos    = cnt_ff[POS_W-1:0];
            upd_tie    = TIE_W'(1);
            upd_winq1  = key.mapq_first;
            upd_winq2  = key.mapq_second;
         end else if (equal) begin
            upd_tie = tie_ff + TIE_W'(1);
         end
         if (key.mapq_first < minq1_ff)  upd_minq1 = key.mapq_first;
         if (key.mapq_second < minq2_ff) upd_minq2 = key.mapq_second;
         upd_cnt = cnt_ff + CNT_W'(1);
      end else begin
         upd_cnt = CNT_W'(MAX_CANDIDATES + 1);
      end
   end

   always_comb begin
      cnt_in    = cnt_ff;
      bpair_in  = bpair_ff;
      bscore_in = bscore_ff;
      bmapq_in  = bmapq_ff;
      pos_in    = pos_ff;
      tie_in    = tie_ff;
      winq1_in  = winq1_ff;
      winq2_in  = winq2_ff;
      minq1_in  = minq1_ff;
      minq2_in  = minq2_ff;
      if (advance) begin
         if (s1_ff.last_candidate) begin
            cnt_in    = '0;
            bpair_in  = 1'b0;
            bscore_in = '0;
            bmapq_in  = '0;
            pos_in    = '0;
            tie_in    = '0;
            winq1_in  = '0;
            winq2_in  = '0;
            minq1_in  = '1;
            minq2_in  = '1;
         end else begin
            cnt_in    = upd_cnt;
            bpair_in  = upd_bpair;
            bscore_in = upd_bscore;
            bmapq_in  = upd_bmapq;
            pos_in    = upd_pos;
            tie_in    = upd_tie;
            winq1_in  = upd_winq1;
            winq2_in  = upd_winq2;
            minq1_in  = upd_minq1;
            minq2_in  = upd_minq2;
         end
      end
   end

   // result register
   assign rsp_load     = advance && s1_ff.last_candidate;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         bpair_ff     <= 1'b0;
         bscore_ff    <= '0;
         bmapq_ff     <= '0;
         pos_ff       <= '0;
         tie_ff       <= '0;
         winq1_ff     <= '0;
         winq2_ff     <= '0;
         minq1_ff     <= '1;
         minq2_ff     <= '1;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         bpair_ff     <= bpair_in;
         bscore_ff    <= bscore_in;
         bmapq_ff     <= bmapq_in;
         pos_ff       <= pos_in;
         tie_ff       <= tie_in;
         winq1_ff     <= winq1_in;
         winq2_ff     <= winq2_in;
         minq1_ff     <= minq1_in;
         minq2_ff     <= minq2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_ff <= req_item;
      end
      if (rsp_load) begin
         rsp_index_ff <= INDEX_W'(upd_pos);
         rsp_tied_ff  <= TIED_W'(upd_tie);
         rsp_score_ff <= upd_bscore;
         rsp_ovf_ff   <= upd_cnt > CNT_W'(MAX_CANDIDATES);
         if (cfg_ff.report_minima) begin
            rsp_q1_ff <= upd_minq1;
            rsp_q2_ff <= cfg_ff.paired_mode ? upd_minq2 : '0;
         end else begin
            rsp_q1_ff <= upd_winq1;
            rsp_q2_ff <= cfg_ff.paired_mode ? upd_winq2 : '0;
         end
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_best_index         = rsp_index_ff;
   assign rsp_tied_count         = rsp_tied_ff;
   assign rsp_best_score         = rsp_score_ff;
   assign rsp_report_mapq_first  = rsp_q1_ff;
   assign rsp_report_mapq_second = rsp_q2_ff;
   assign rsp_count_overflow     = rsp_ovf_ff;

endmodule
